// ===== design/wsfe_pkg.sv =====
// shared types, constants and header byte functions for the websocket frame encoder
`default_nettype none

package wsfe_pkg;

    // defaults for the top level parameters
    localparam int LENGTH_BITS_DEF = 32;
    localparam int QUEUE_DEPTH_DEF = 4;

    // fixed field widths
    localparam int FIELD_W = 32;
    localparam int BYTE_W  = 8;
    localparam int IDX_W   = 4;

    // reset value of the frame size limit
    localparam logic [FIELD_W-1:0] FRAME_LIMIT_RST = 32'd2200;

    // header codes
    localparam logic [BYTE_W-1:0] OP_TEXT    = 8'h81;
    localparam logic [BYTE_W-1:0] OP_BINARY  = 8'h82;
    localparam logic [BYTE_W-1:0] MASK_BIT   = 8'h80;
    localparam logic [6:0]        LEN16_CODE = 7'd126;
    localparam logic [6:0]        LEN64_CODE = 7'd127;

    // length form thresholds
    localparam logic [FIELD_W-1:0] LEN7_MAX  = 32'd125;
    localparam logic [FIELD_W-1:0] LEN16_MAX = 32'd65535;

    // whole header sizes per length form
    localparam logic [IDX_W-1:0] HDR_LEN7  = 4'd6;
    localparam logic [IDX_W-1:0] HDR_LEN16 = 4'd8;
    localparam logic [IDX_W-1:0] HDR_LEN64 = 4'd14;

    // index of the first mask key byte per length form
    localparam logic [IDX_W-1:0] KEY_POS7  = 4'd2;
    localparam logic [IDX_W-1:0] KEY_POS16 = 4'd4;
    localparam logic [IDX_W-1:0] KEY_POS64 = 4'd10;

    // positions of the fixed header bytes
    localparam logic [IDX_W-1:0] POS_OPCODE = 4'd0;
    localparam logic [IDX_W-1:0] POS_LENGTH = 4'd1;

    typedef enum logic [1:0] {
        CMD_HDR,
        CMD_ERR,
        CMD_DATA
    } cmd_kind_t;

    typedef enum logic [1:0] {
        FORM_7,
        FORM_16,
        FORM_64
    } len_form_t;

    // one unit of work for the back end
    typedef struct packed {
        cmd_kind_t          kind;
        len_form_t          form;
        logic               text;
        logic [FIELD_W-1:0] len;
        logic [FIELD_W-1:0] key;
        logic [BYTE_W-1:0]  data;
        logic               last;
    } cmd_t;

    // number of output bytes a command expands to
    function automatic logic [IDX_W-1:0] cmd_count(cmd_t c);
        logic [IDX_W-1:0] n;
        n = 4'd1;
        if (c.kind == CMD_HDR) begin
            unique case (c.form)
                FORM_7:  n = HDR_LEN7;
                FORM_16: n = HDR_LEN16;
                FORM_64: n = HDR_LEN64;
                default: n = HDR_LEN64;
            endcase
        end
        return n;
    endfunction

    // header byte at position i of a header command
    function automatic logic [BYTE_W-1:0] hdr_byte(cmd_t c, logic [IDX_W-1:0] i);
        logic [63:0]       len64;
        logic [IDX_W-1:0]  key_pos;
        logic [IDX_W-1:0]  k;
        logic [IDX_W-1:0]  e;
        logic [6:0]        code;
        logic [BYTE_W-1:0] b;
        len64 = 64'(c.len);
        unique case (c.form)
            FORM_7: begin
                key_pos = KEY_POS7;
                code    = c.len[6:0];
            end
            FORM_16: begin
                key_pos = KEY_POS16;
                code    = LEN16_CODE;
            end
            FORM_64: begin
                key_pos = KEY_POS64;
                code    = LEN64_CODE;
            end
            default: begin
                key_pos = KEY_POS64;
                code    = LEN64_CODE;
            end
        endcase
        k = i - key_pos;
        e = key_pos - 4'd1 - i;
        if (i == POS_OPCODE) begin
            b = c.text ? OP_TEXT : OP_BINARY;
        end else if (i == POS_LENGTH) begin
            b = MASK_BIT | {1'b0, code};
        end else if (i >= key_pos) begin
            b = c.key[{2'd3 - k[1:0], 3'b000} +: 8];
        end else begin
            // extended length, big endian, e counts back from the last length byte
            b = 8'(len64 >> {e[2:0], 3'b000});
        end
        return b;
    endfunction

endpackage

`default_nettype wire

// ===== design/wsfe_front.sv =====
// front end: accepts items, keeps frame state, masks payload and queues commands
`default_nettype none

module wsfe_front #(
    parameter int LENGTH_BITS = wsfe_pkg::LENGTH_BITS_DEF
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          s_valid,
    output logic                               s_ready,
    input  wire logic                          s_req_type,
    input  wire logic [wsfe_pkg::FIELD_W-1:0]  s_payload_length,
    input  wire logic [wsfe_pkg::FIELD_W-1:0]  s_mask_key,
    input  wire logic                          s_text_frame,
    input  wire logic [wsfe_pkg::BYTE_W-1:0]   s_payload_byte,
    input  wire logic                          cfg_valid,
    output logic                               cfg_ready,
    input  wire logic [wsfe_pkg::FIELD_W-1:0]  cfg_data,
    input  wire logic                          q_full,
    output logic                               q_push,
    output wsfe_pkg::cmd_t                     q_cmd
);
    import wsfe_pkg::*;

    // lengths are held modulo 2^LENGTH_BITS, never wider than the input field
    localparam int LEN_W = (LENGTH_BITS < FIELD_W) ? LENGTH_BITS : FIELD_W;

    logic [FIELD_W-1:0] frame_limit_reg, frame_limit_next;
    logic [LEN_W-1:0]   bytes_left_reg, bytes_left_next;
    logic [FIELD_W-1:0] mask_reg, mask_next;
    logic [1:0]         phase_reg, phase_next;
    logic               dropping_reg, dropping_next;

    logic               accept;
    logic [FIELD_W-1:0] len32;
    len_form_t          form;
    logic [IDX_W-1:0]   hlen;
    logic [FIELD_W:0]   total;
    logic               too_big;
    logic [BYTE_W-1:0]  mask_byte;

    assign s_ready   = !q_full;
    assign cfg_ready = 1'b1;
    assign accept    = s_valid && s_ready;

    // classify the length of a start item
    assign len32 = FIELD_W'(s_payload_length[LEN_W-1:0]);

    always_comb begin
        if (len32 <= LEN7_MAX) begin
            form = FORM_7;
            hlen = HDR_LEN7;
        end else if (len32 <= LEN16_MAX) begin
            form = FORM_16;
            hlen = HDR_LEN16;
        end else begin
            form = FORM_64;
            hlen = HDR_LEN64;
        end
    end

    assign total   = (FIELD_W+1)'(len32) + (FIELD_W+1)'(hlen);
    assign too_big = total > (FIELD_W+1)'(frame_limit_reg);

    // mask byte for the next payload byte
    assign mask_byte = mask_reg[{2'd3 - phase_reg, 3'b000} +: 8];

    // state update and command build
    always_comb begin
        frame_limit_next = frame_limit_reg;
        bytes_left_next  = bytes_left_reg;
        mask_next        = mask_reg;
        phase_next       = phase_reg;
        dropping_next    = dropping_reg;
        q_push           = 1'b0;
        q_cmd            = '0;
        q_cmd.kind       = CMD_DATA;
        q_cmd.form       = form;
        q_cmd.text       = s_text_frame;
        q_cmd.len        = len32;
        q_cmd.key        = s_mask_key;
        q_cmd.data       = s_payload_byte ^ mask_byte;
        q_cmd.last       = (bytes_left_reg == LEN_W'(1));

        if (cfg_valid && cfg_ready) begin
            frame_limit_next = cfg_data;
        end

        if (accept) begin
            if (!s_req_type) begin
                // start item, opens a frame or refuses it
                phase_next      = 2'd0;
                bytes_left_next = s_payload_length[LEN_W-1:0];
                q_push          = 1'b1;
                if (too_big) begin
                    dropping_next = 1'b1;
                    q_cmd.kind    = CMD_ERR;
                end else begin
                    dropping_next = 1'b0;
                    mask_next     = s_mask_key;
                    q_cmd.kind    = CMD_HDR;
                end
            end else if (bytes_left_reg != '0) begin
                // payload item of an open frame
                bytes_left_next = bytes_left_reg - LEN_W'(1);
                if (!dropping_reg) begin
                    phase_next = phase_reg + 2'd1;
                    q_push     = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            frame_limit_reg <= FRAME_LIMIT_RST;
            bytes_left_reg  <= '0;
            mask_reg        <= '0;
            phase_reg       <= 2'd0;
            dropping_reg    <= 1'b0;
        end else begin
            frame_limit_reg <= frame_limit_next;
            bytes_left_reg  <= bytes_left_next;
            mask_reg        <= mask_next;
            phase_reg       <= phase_next;
            dropping_reg    <= dropping_next;
        end
    end

endmodule

`default_nettype wire

// ===== design/wsfe_queue.sv =====
// command queue between the front and back ends
`default_nettype none

module wsfe_queue #(
    parameter int DEPTH = wsfe_pkg::QUEUE_DEPTH_DEF
) (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           push,
    input  wsfe_pkg::cmd_t      push_cmd,
    output logic                full,
    input  wire logic           pop,
    output logic                not_empty,
    output wsfe_pkg::cmd_t      head
);
    import wsfe_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    cmd_t             entry_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push, do_pop;

    assign full      = (count_reg == CNT_W'(DEPTH));
    assign not_empty = (count_reg != '0);
    assign head      = entry_reg[rd_ptr_reg];
    assign do_push   = push && !full;
    assign do_pop    = pop && not_empty;

    // pointer and fill count update
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + CNT_W'(1);
        end else if (do_pop && !do_push) begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // storage, no reset needed
    always_ff @(posedge aclk) begin
        if (do_push) begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

`default_nettype wire

// ===== design/wsfe_back.sv =====
// back end: expands queued commands into output bytes, one per cycle while m_ready allows
`default_nettype none

module wsfe_back (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         q_not_empty,
    input  wsfe_pkg::cmd_t                    q_head,
    output logic                              q_pop,
    output logic                              m_valid,
    input  wire logic                         m_ready,
    output logic [wsfe_pkg::BYTE_W-1:0]       m_out_byte,
    output logic                              m_run_last,
    output logic                              m_frame_end,
    output logic                              m_too_large
);
    import wsfe_pkg::*;

    logic [IDX_W-1:0]  idx_reg, idx_next;
    logic              valid_reg, valid_next;
    logic [BYTE_W-1:0] byte_reg;
    logic              last_reg, end_reg, big_reg;

    logic              out_free, fire, is_last;
    logic [BYTE_W-1:0] byte_d;
    logic              last_d, end_d, big_d;

    assign out_free = !valid_reg || m_ready;
    assign fire     = q_not_empty && out_free;
    assign is_last  = (idx_reg == cmd_count(q_head) - 4'd1);
    assign q_pop    = fire && is_last;

    // byte selection for the command at the queue head
    always_comb begin
        unique case (q_head.kind)
            CMD_HDR: begin
                byte_d = hdr_byte(q_head, idx_reg);
                last_d = is_last;
                end_d  = is_last && (q_head.len == '0);
                big_d  = 1'b0;
            end
            CMD_ERR: begin
                byte_d = '0;
                last_d = 1'b1;
                end_d  = 1'b0;
                big_d  = 1'b1;
            end
            CMD_DATA: begin
                byte_d = q_head.data;
                last_d = 1'b1;
                end_d  = q_head.last;
                big_d  = 1'b0;
            end
            default: begin
                byte_d = '0;
                last_d = 1'b0;
                end_d  = 1'b0;
                big_d  = 1'b0;
            end
        endcase
    end

    // byte index within the current command and output valid
    always_comb begin
        idx_next   = idx_reg;
        valid_next = valid_reg;
        if (out_free) begin
            valid_next = q_not_empty;
        end
        if (fire) begin
            idx_next = is_last ? '0 : idx_reg + 4'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg   <= '0;
            valid_reg <= 1'b0;
        end else begin
            idx_reg   <= idx_next;
            valid_reg <= valid_next;
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (fire) begin
            byte_reg <= byte_d;
            last_reg <= last_d;
            end_reg  <= end_d;
            big_reg  <= big_d;
        end
    end

    assign m_valid     = valid_reg;
    assign m_out_byte  = byte_reg;
    assign m_run_last  = last_reg;
    assign m_frame_end = end_reg;
    assign m_too_large = big_reg;

endmodule

`default_nettype wire

// ===== design/websocket_frame_encoder.sv =====
// top level of the websocket client frame encoder
//
// Builds masked client-to-server WebSocket frames as a byte stream. A start item
// (req_type 0) gives the opcode byte, the length byte, the 16-bit or 64-bit
// big-endian extended length where needed, and the four mask key bytes: 6, 8 or
// 14 output transfers, or one error transfer with too_large set when header plus
// payload would exceed frame_limit; the payload of a refused frame is then
// dropped. Each payload item (req_type 1) gives one byte XORed with the mask. The
// front end takes one item per cycle as long as the command queue (QUEUE_DEPTH
// entries) has room; the back end drains one output byte per cycle from the
// output register while m_ready is high, so a start item holds the output side
// until all its header bytes are out. Payload items with no open frame are
// accepted and give nothing. frame_limit is written through the cfg port, always
// ready, and should only change while the block is idle.
`default_nettype none

module websocket_frame_encoder #(
    parameter int LENGTH_BITS = wsfe_pkg::LENGTH_BITS_DEF,
    parameter int QUEUE_DEPTH = wsfe_pkg::QUEUE_DEPTH_DEF
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          s_valid,
    output logic                               s_ready,
    input  wire logic                          s_req_type,
    input  wire logic [wsfe_pkg::FIELD_W-1:0]  s_payload_length,
    input  wire logic [wsfe_pkg::FIELD_W-1:0]  s_mask_key,
    input  wire logic                          s_text_frame,
    input  wire logic [wsfe_pkg::BYTE_W-1:0]   s_payload_byte,
    output logic                               m_valid,
    input  wire logic                          m_ready,
    output logic [wsfe_pkg::BYTE_W-1:0]        m_out_byte,
    output logic                               m_run_last,
    output logic                               m_frame_end,
    output logic                               m_too_large,
    input  wire logic                          cfg_valid,
    output logic                               cfg_ready,
    input  wire logic [wsfe_pkg::FIELD_W-1:0]  cfg_data
);
    import wsfe_pkg::*;

    cmd_t q_cmd;
    cmd_t q_head;
    logic q_push, q_full, q_pop, q_not_empty;

    wsfe_front #(
        .LENGTH_BITS(LENGTH_BITS)
    ) u_front (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_req_type      (s_req_type),
        .s_payload_length(s_payload_length),
        .s_mask_key      (s_mask_key),
        .s_text_frame    (s_text_frame),
        .s_payload_byte  (s_payload_byte),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_data        (cfg_data),
        .q_full          (q_full),
        .q_push          (q_push),
        .q_cmd           (q_cmd)
    );

    wsfe_queue #(
        .DEPTH(QUEUE_DEPTH)
    ) u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (q_push),
        .push_cmd (q_cmd),
        .full     (q_full),
        .pop      (q_pop),
        .not_empty(q_not_empty),
        .head     (q_head)
    );

    wsfe_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .q_not_empty(q_not_empty),
        .q_head     (q_head),
        .q_pop      (q_pop),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_out_byte (m_out_byte),
        .m_run_last (m_run_last),
        .m_frame_end(m_frame_end),
        .m_too_large(m_too_large)
    );

    // an error transfer is a lone zero byte that closes its run but not a frame
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_too_large |-> m_out_byte == '0 && m_run_last && !m_frame_end)
        else $error("error transfer has bad fields");

    // the end of a frame always closes the run of its item
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_frame_end |-> m_run_last)
        else $error("frame end without run last");

    // the front end never pushes into a full queue
    assert property (@(posedge aclk) disable iff (!aresetn)
        q_push |-> !q_full)
        else $error("command queue overflow");

    // an empty queue is never popped
    assert property (@(posedge aclk) disable iff (!aresetn)
        q_pop |-> q_not_empty)
        else $error("command queue underflow");

endmodule

`default_nettype wire
